>>> rtl/core/pfdd_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, microcode step names and the control store of
// the sequencer that runs one controller update.
// ----------------------------------------------------------------------------
package pfdd_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int ERR_W      = DATA_WIDTH + 1;
    localparam int DIFF_W     = DATA_WIDTH + 2;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int FRAC_BITS  = 8;
    localparam int MUL_A_W    = GAIN_W + 2;
    localparam int MUL_B_W    = 36;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int INTEG_W    = LIM_W + FRAC_BITS + 2;
    localparam int ISUM_W     = 35;
    localparam int ACC_W      = 36;
    localparam int FILT_W     = 32;
    localparam int RES_W      = ACC_W - FRAC_BITS;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 4;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_GAIN_P     = 3'd0;
    localparam t_cfg_addr CFG_GAIN_I     = 3'd1;
    localparam t_cfg_addr CFG_GAIN_D     = 3'd2;
    localparam t_cfg_addr CFG_OUT_LIMIT  = 3'd3;
    localparam t_cfg_addr CFG_INT_LIMIT  = 3'd4;
    localparam t_cfg_addr CFG_DEADBAND   = 3'd5;
    localparam t_cfg_addr CFG_FILTER     = 3'd6;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT     = 4'd0;
    localparam t_step STEP_MUL_P    = 4'd1;
    localparam t_step STEP_MUL_I    = 4'd2;
    localparam t_step STEP_MUL_D    = 4'd3;
    localparam t_step STEP_MUL_NEW  = 4'd4;
    localparam t_step STEP_MUL_OLD  = 4'd5;
    localparam t_step STEP_FILTER   = 4'd6;
    localparam t_step STEP_SUM      = 4'd7;
    localparam t_step STEP_OUT      = 4'd8;

    typedef enum logic [2:0] {
        A_GP,
        A_GI,
        A_GD,
        A_COEF,
        A_COEFC
    } t_asel;

    typedef enum logic [1:0] {
        B_ERR,
        B_DIFF,
        B_PROD,
        B_FILT
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_PROD,
        ACC_ADD_INTEG,
        ACC_ADD_FILT
    } t_accop;

    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_HOME
    } t_jmp;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   mul_en;
        t_accop acc_op;
        logic   integ_en;
        logic   facc_en;
        logic   filt_en;
        t_jmp   jmp;
    } t_ucode;

    function automatic t_ucode ucode_rom(input t_step step);
        t_ucode w;
        w = '{a_sel: A_GP, b_sel: B_ERR, mul_en: 1'b0, acc_op: ACC_HOLD,
              integ_en: 1'b0, facc_en: 1'b0, filt_en: 1'b0, jmp: J_HOME};
        case (step)
            STEP_WAIT: begin
                w.jmp = J_WAIT_IN;
            end
            STEP_MUL_P: begin
                w.a_sel  = A_GP;
                w.b_sel  = B_ERR;
                w.mul_en = 1'b1;
                w.jmp    = J_NEXT;
            end
            STEP_MUL_I: begin
                w.a_sel  = A_GI;
                w.b_sel  = B_ERR;
                w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD_PROD;
                w.jmp    = J_NEXT;
            end
            STEP_MUL_D: begin
                w.a_sel    = A_GD;
                w.b_sel    = B_DIFF;
                w.mul_en   = 1'b1;
                w.integ_en = 1'b1;
                w.jmp      = J_NEXT;
            end
            STEP_MUL_NEW: begin
                w.a_sel  = A_COEF;
                w.b_sel  = B_PROD;
                w.mul_en = 1'b1;
                w.acc_op = ACC_ADD_INTEG;
                w.jmp    = J_NEXT;
            end
            STEP_MUL_OLD: begin
                w.a_sel   = A_COEFC;
                w.b_sel   = B_FILT;
                w.mul_en  = 1'b1;
                w.facc_en = 1'b1;
                w.jmp     = J_NEXT;
            end
            STEP_FILTER: begin
                w.filt_en = 1'b1;
                w.jmp     = J_NEXT;
            end
            STEP_SUM: begin
                w.acc_op = ACC_ADD_FILT;
                w.jmp    = J_NEXT;
            end
            STEP_OUT: begin
                w.jmp = J_WAIT_OUT;
            end
            default: begin
                w.jmp = J_HOME;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/pid_filtered_derivative_deadband_top.sv
// ----------------------------------------------------------------------------
// PID controller with filtered derivative and deadband
// Microcoded sequencer over one shared 18 x 36 multiplier computes the
// proportional, clamped integral and low-pass derivative terms per word.
// ----------------------------------------------------------------------------
// Sequencing: an update word runs the eight microcode steps MUL_P to OUT after
//          the wait step takes it; a clear word goes from the wait step to OUT.
//          A waiting result holds the sequencer in OUT, and no new word is taken
//          until it returns to the wait step.
// Reset: synchronous, active low; clears controller state, the sequencer and
//          the output valid, and loads the register reset values.
module pid_filtered_derivative_deadband_top
    import pfdd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [2*DATA_WIDTH-1:0]  s_axis_tdata,   // target, measured
    input  logic                     s_axis_tuser,   // cmd
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [DATA_WIDTH-1:0]    m_axis_tdata,   // drive
    output logic                     m_axis_tuser    // saturated
);

    logic [GAIN_W-1:0]          r_gain_p, r_gain_i, r_gain_d, r_coef;
    logic [LIM_W-1:0]           r_out_lim, r_int_lim, r_deadband;

    t_step                      r_step, n_step;
    t_ucode                     uc;

    logic signed [ERR_W-1:0]    r_err, r_last, err_in;
    logic signed [DIFF_W-1:0]   r_diff;
    logic                       r_clr;
    logic signed [PROD_W-1:0]   r_prod, r_facc;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [FILT_W-1:0]   r_filt;

    logic                       r_m_tvalid;
    logic [DATA_WIDTH-1:0]      r_drive;
    logic                       r_sat;

    logic                       in_acc, out_free;
    logic [MUL_A_W-2:0]         a_u;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ISUM_W-1:0]   isum, ilim;
    logic signed [PROD_W-1:0]   fsum;
    logic signed [PROD_W-17:0]  fsh;
    logic [ERR_W-1:0]           aerr;
    logic signed [RES_W-1:0]    res, olim;
    logic [DATA_WIDTH-1:0]      n_drive;
    logic                       n_sat;

    assign uc            = ucode_rom(r_step);
    assign s_axis_tready = (r_step == STEP_WAIT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_tvalid || m_axis_tready;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = r_sat;

    assign err_in = $signed({s_axis_tdata[DATA_WIDTH-1], s_axis_tdata[DATA_WIDTH-1:0]})
                  - $signed({s_axis_tdata[2*DATA_WIDTH-1],
                             s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_out_lim  <= '1;
            r_int_lim  <= '1;
            r_deadband <= '0;
            r_coef     <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_P:    r_gain_p   <= i_cfg_wdata;
                CFG_GAIN_I:    r_gain_i   <= i_cfg_wdata;
                CFG_GAIN_D:    r_gain_d   <= i_cfg_wdata;
                CFG_OUT_LIMIT: r_out_lim  <= i_cfg_wdata[LIM_W-1:0];
                CFG_INT_LIMIT: r_int_lim  <= i_cfg_wdata[LIM_W-1:0];
                CFG_DEADBAND:  r_deadband <= i_cfg_wdata[LIM_W-1:0];
                CFG_FILTER:    r_coef     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_step = r_step;
        case (uc.jmp)
            J_NEXT:     n_step = r_step + 1'b1;
            J_WAIT_IN: begin
                if (in_acc) begin
                    n_step = s_axis_tuser ? STEP_OUT : STEP_MUL_P;
                end
            end
            J_WAIT_OUT: begin
                if (out_free) begin
                    n_step = STEP_WAIT;
                end
            end
            J_HOME:     n_step = STEP_WAIT;
            default:    n_step = STEP_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        case (uc.a_sel)
            A_GP:    a_u = {1'b0, r_gain_p};
            A_GI:    a_u = {1'b0, r_gain_i};
            A_GD:    a_u = {1'b0, r_gain_d};
            A_COEF:  a_u = {1'b0, r_coef};
            A_COEFC: a_u = {1'b1, {GAIN_W{1'b0}}} - {1'b0, r_coef};
            default: a_u = '0;
        endcase
        mul_a = $signed({1'b0, a_u});
        case (uc.b_sel)
            B_ERR:   mul_b = MUL_B_W'(r_err);
            B_DIFF:  mul_b = MUL_B_W'(r_diff);
            B_PROD:  mul_b = r_prod[MUL_B_W-1:0];
            B_FILT:  mul_b = MUL_B_W'(r_filt);
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        isum = ISUM_W'(r_integ) + r_prod[ISUM_W-1:0];
        ilim = $signed({{(ISUM_W-LIM_W-FRAC_BITS){1'b0}}, r_int_lim, {FRAC_BITS{1'b0}}});
        fsum = r_facc + r_prod;
        fsh  = fsum[PROD_W-1:16];
    end

    always_comb begin
        aerr    = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        olim    = $signed({{(RES_W-LIM_W){1'b0}}, r_out_lim});
        res     = (aerr < {{(ERR_W-LIM_W){1'b0}}, r_deadband}) ? '0 : r_acc[ACC_W-1:FRAC_BITS];
        n_sat   = 1'b0;
        n_drive = res[DATA_WIDTH-1:0];
        if (res > olim) begin
            n_drive = olim[DATA_WIDTH-1:0];
            n_sat   = 1'b1;
        end else if (res < -olim) begin
            n_drive = DATA_WIDTH'(-olim);
            n_sat   = 1'b1;
        end
        if (r_clr) begin
            n_drive = '0;
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_integ <= '0;
            r_filt  <= '0;
        end else begin
            if (in_acc && s_axis_tuser) begin
                r_last  <= '0;
                r_integ <= '0;
                r_filt  <= '0;
            end
            if (uc.integ_en) begin
                if (isum > ilim) begin
                    r_integ <= ilim[INTEG_W-1:0];
                end else if (isum < -ilim) begin
                    r_integ <= INTEG_W'(-ilim);
                end else begin
                    r_integ <= isum[INTEG_W-1:0];
                end
            end
            if (uc.filt_en) begin
                r_last <= r_err;
                if (fsh > $signed(38'sh007FFFFFFF)) begin
                    r_filt <= 32'sh7FFFFFFF;
                end else if (fsh < $signed(38'sh3F80000000)) begin
                    r_filt <= 32'sh80000000;
                end else begin
                    r_filt <= fsh[FILT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_err  <= err_in;
            r_diff <= DIFF_W'(err_in) - DIFF_W'(r_last);
            r_clr  <= s_axis_tuser;
        end
        if (uc.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (uc.facc_en) begin
            r_facc <= r_prod;
        end
        case (uc.acc_op)
            ACC_LOAD_PROD: r_acc <= r_prod[ACC_W-1:0];
            ACC_ADD_INTEG: r_acc <= r_acc + ACC_W'(r_integ);
            ACC_ADD_FILT:  r_acc <= r_acc + ACC_W'(r_filt);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (r_step == STEP_OUT && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_step == STEP_OUT && out_free) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

endmodule

>>> rtl/core/pfdd_checker.sv
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the stream ports of the controller top level over time.
// ----------------------------------------------------------------------------
module pfdd_port_assert
    import pfdd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     s_axis_tuser,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [DATA_WIDTH-1:0]    m_axis_tdata,
    input logic                     m_axis_tuser
);

    a_busy_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after a word");

    a_update_takes_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=>
            !s_axis_tready ##1 !s_axis_tready)
        else $error("update word finished too early");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a word in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_sat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            m_axis_tdata != {1'b1, {(DATA_WIDTH-1){1'b0}}})
        else $error("saturated drive outside symmetric limit");

endmodule

bind pid_filtered_derivative_deadband_top pfdd_port_assert u_pfdd_port_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> bench/pfdd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller checker
// Watches the register port and both stream channels of the controller,
// predicts each drive word from its own copy of the loop state and compares
// every accepted output word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pfdd_checker
    import pfdd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [2*DATA_WIDTH-1:0]  i_in_data,   // target, measured
    input  logic                     i_in_user,   // cmd
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [DATA_WIDTH-1:0]    i_out_data,  // drive
    input  logic                     i_out_user,  // saturated
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] drive;
        logic                  sat;
    } t_drive_word;

    localparam longint RAW_D_MAX = longint'(1) <<< 47;
    localparam longint FILT_MAX  = 64'sd2147483647;
    localparam longint FILT_MIN  = -64'sd2147483648;

    logic [GAIN_W-1:0] kp, ki, kd, coef;
    logic [LIM_W-1:0]  olim, ilim, dband;

    longint err_prev, integ, filt_state;

    t_drive_word drive_q[$];
    t_drive_word want;
    int          fail_total = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (fail_total < 100)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, exp_val);
        fail_total++;
    endtask

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic t_drive_word pid_update(input logic cmd,
                                               input logic [DATA_WIDTH-1:0] tgt,
                                               input logic [DATA_WIDTH-1:0] meas);
        longint      err, bound, raw, filt, sum, res, mag;
        t_drive_word w;
        w = '0;
        if (cmd) begin
            err_prev   = 0;
            integ      = 0;
            filt_state = 0;
            return w;
        end
        err   = longint'($signed(tgt)) - longint'($signed(meas));
        bound = longint'(ilim) <<< FRAC_BITS;
        integ = clip(integ + longint'(kp * 0 + ki) * err, -bound, bound);
        raw   = clip(longint'(kd) * (err - err_prev), -RAW_D_MAX, RAW_D_MAX);
        filt  = (longint'(coef) * raw + (longint'(65536) - longint'(coef)) * filt_state)
                >>> 16;
        filt       = clip(filt, FILT_MIN, FILT_MAX);
        filt_state = filt;
        err_prev   = err;
        sum = longint'(kp) * err + integ + filt;
        mag = (err < 0) ? -err : err;
        // force zero inside the deadband, ahead of the output clamp
        if (mag < longint'(dband))
            sum = 0;
        res = sum >>> FRAC_BITS;
        if (res > longint'(olim)) begin
            res   = longint'(olim);
            w.sat = 1'b1;
        end else if (res < -longint'(olim)) begin
            res   = -longint'(olim);
            w.sat = 1'b1;
        end
        w.drive = res[DATA_WIDTH-1:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kp         = '0;
            ki         = '0;
            kd         = '0;
            olim       = 15'h7FFF;
            ilim       = 15'h7FFF;
            dband      = '0;
            coef       = 16'hFFFF;
            err_prev   = 0;
            integ      = 0;
            filt_state = 0;
            drive_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected word", {15'd0, i_out_user, i_out_data}, 0);
                end else begin
                    want = drive_q.pop_front();
                    if (i_out_data !== want.drive)
                        report_mismatch("drive", 32'(i_out_data), 32'(want.drive));
                    if (i_out_user !== want.sat)
                        report_mismatch("saturated", 32'(i_out_user), 32'(want.sat));
                end
            end
            if (i_in_valid && i_in_ready)
                drive_q.push_back(pid_update(i_in_user, i_in_data[DATA_WIDTH-1:0],
                                             i_in_data[2*DATA_WIDTH-1:DATA_WIDTH]));
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN_P:    kp    = i_cfg_wdata;
                    CFG_GAIN_I:    ki    = i_cfg_wdata;
                    CFG_GAIN_D:    kd    = i_cfg_wdata;
                    CFG_OUT_LIMIT: olim  = i_cfg_wdata[LIM_W-1:0];
                    CFG_INT_LIMIT: ilim  = i_cfg_wdata[LIM_W-1:0];
                    CFG_DEADBAND:  dband = i_cfg_wdata[LIM_W-1:0];
                    CFG_FILTER:    coef  = i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= drive_q.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives directed and random update and clear words through the controller
// under several register settings and idling patterns on both channels, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
    import pfdd_pkg::*;

    localparam int        CYCLE_LIMIT  = 300000;
    localparam int        SEGMENTS     = 12;
    localparam int        SEG_WORDS    = 130;
    localparam t_cfg_addr CFG_NO_REG   = 3'd7;
    localparam logic      CMD_UPDATE   = 1'b0;
    localparam logic      CMD_CLEAR    = 1'b1;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata   = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [2*DATA_WIDTH-1:0] s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_WIDTH-1:0]   m_axis_tdata;
    logic                    m_axis_tuser;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_in    = 26;
    int stall_out   = 52;

    logic [GAIN_W-1:0] gp, gi, gd, fc;
    logic [LIM_W-1:0]  olim, ilim, dbnd;

    pid_filtered_derivative_deadband_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pfdd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= stall_out);

    task automatic send_word(input logic cmd, input logic [DATA_WIDTH-1:0] tgt,
                             input logic [DATA_WIDTH-1:0] meas);
        while ($urandom_range(99) < stall_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {meas, tgt};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_addr addr, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // unused top bit of the narrow registers is driven at random to check masking
    task automatic program_regs(input bit stray_write);
        put_reg(CFG_GAIN_P, gp);
        put_reg(CFG_GAIN_I, gi);
        put_reg(CFG_GAIN_D, gd);
        put_reg(CFG_OUT_LIMIT, {1'($urandom_range(1)), olim});
        put_reg(CFG_INT_LIMIT, {1'($urandom_range(1)), ilim});
        put_reg(CFG_DEADBAND, {1'($urandom_range(1)), dbnd});
        put_reg(CFG_FILTER, fc);
        if (stray_write)
            put_reg(CFG_NO_REG, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_settings();
        int mode;
        mode = $urandom_range(5);
        case (mode)
            0: begin
                gp   = 16'hFFFF;
                gi   = 16'hFFFF;
                gd   = 16'hFFFF;
                olim = 15'h7FFF;
                ilim = 15'h7FFF;
                dbnd = $urandom_range(1) ? 15'h7FFF : 15'h0000;
                fc   = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            1: begin
                gp   = 16'($urandom);
                gi   = 16'($urandom);
                gd   = 16'($urandom);
                olim = '0;
                ilim = '0;
                dbnd = '0;
                fc   = '0;
            end
            default: begin
                gp   = 16'($urandom) >> $urandom_range(15);
                gi   = 16'($urandom) >> $urandom_range(15);
                gd   = 16'($urandom) >> $urandom_range(15);
                olim = 15'($urandom) >> $urandom_range(6);
                ilim = 15'($urandom) >> $urandom_range(8);
                dbnd = 15'($urandom) >> $urandom_range(4, 15);
                fc   = 16'($urandom);
            end
        endcase
    endtask

    task automatic random_word();
        int                    kind;
        logic [DATA_WIDTH-1:0] tgt, meas;
        kind = $urandom_range(99);
        tgt  = 16'($urandom);
        meas = 16'($urandom);
        if (kind < 5) begin
            send_word(CMD_CLEAR, tgt, meas);
        end else begin
            if (kind < 55) begin
                meas = tgt + 16'd200 - 16'($urandom_range(400));
            end else if (kind < 70) begin
                tgt  = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                meas = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            send_word(CMD_UPDATE, tgt, meas);
        end
    endtask

    initial begin
        int seg, n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register reset values
        send_word(CMD_UPDATE, 16'd1000, -16'sd1000);
        send_word(CMD_UPDATE, 16'h7FFF, 16'h8000);
        drain();

        gp = 16'd256; gi = 16'd64; gd = 16'd512; fc = 16'h8000;
        olim = 15'd1000; ilim = 15'd500; dbnd = 15'd10;
        program_regs(1'b1);
        send_word(CMD_UPDATE, 16'h7FFF, 16'h8000);
        send_word(CMD_UPDATE, 16'h8000, 16'h7FFF);
        send_word(CMD_UPDATE, 16'd0, 16'd0);
        send_word(CMD_UPDATE, 16'd9, 16'd0);
        send_word(CMD_UPDATE, 16'd10, 16'd0);
        send_word(CMD_UPDATE, 16'd0, 16'd9);
        send_word(CMD_UPDATE, 16'd0, 16'd10);
        send_word(CMD_CLEAR, 16'h7FFF, 16'h8000);
        repeat (3) send_word(CMD_UPDATE, 16'd3000, 16'd0);
        send_word(CMD_UPDATE, -16'sd3000, 16'd0);
        drain();

        // full gains: derivative filter saturates on large swings
        gp = 16'hFFFF; gi = 16'hFFFF; gd = 16'hFFFF; fc = 16'hFFFF;
        olim = 15'h7FFF; ilim = 15'h7FFF; dbnd = 15'd0;
        program_regs(1'b0);
        send_word(CMD_UPDATE, 16'h7FFF, 16'h8000);
        send_word(CMD_UPDATE, 16'h8000, 16'h7FFF);
        send_word(CMD_UPDATE, 16'h7FFF, 16'h8000);
        drain();

        fc = 16'h0000; olim = 15'd0; ilim = 15'd0; dbnd = 15'h7FFF;
        program_regs(1'b0);
        send_word(CMD_UPDATE, 16'h7FFF, 16'h8000);
        send_word(CMD_UPDATE, 16'h8000, 16'h7FFF);
        send_word(CMD_UPDATE, 16'h7FFF, 16'd0);
        send_word(CMD_CLEAR, 16'd0, 16'd0);
        drain();

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < SEGMENTS / 3) begin
                stall_in  = 26;
                stall_out = 52;
            end else if (seg < 2 * SEGMENTS / 3) begin
                stall_in  = 52;
                stall_out = 26;
            end else begin
                stall_in  = 0;
                stall_out = 0;
            end
            pick_settings();
            program_regs(seg[0]);
            for (n = 0; n < SEG_WORDS; n++)
                random_word();
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
